FILE: sv/olc_pkg.sv
// shared constants, types and codes of the ordered list unit
`default_nettype none

package olc_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned ENTRY_BITS = 32;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned OUT_CNT_W  = 5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_PEEK   = 2'd3
  } olc_action_e;

  typedef struct packed {
    logic                 accepted;
    logic [VALUE_W-1:0]   front_value;
    logic [VALUE_W-1:0]   back_value;
    logic                 list_empty;
    logic [OUT_CNT_W-1:0] entry_count;
  } olc_result_t;

endpackage

`default_nettype wire

FILE: sv/olc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module olc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/olc_ctrl.sv
// sequencer: push, remove with shift-down through ram, clear, peek, front/back readout
`default_nettype none

module olc_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire olc_pkg::olc_action_e             action_i,
  input  wire logic [olc_pkg::VALUE_W-1:0]      entry_value_i,
  input  wire logic [olc_pkg::POS_W-1:0]        entry_position_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output olc_pkg::olc_result_t                  res_o,
  output logic                                  mem_we_o,
  output logic [olc_pkg::IDX_W-1:0]             mem_waddr_o,
  output logic [olc_pkg::ENTRY_BITS-1:0]        mem_wdata_o,
  output logic [olc_pkg::IDX_W-1:0]             mem_raddr_o,
  input  wire logic [olc_pkg::ENTRY_BITS-1:0]   mem_rdata_i
);

  import olc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SHIFT    = 6'b000010,
    ST_RD_FRONT = 6'b000100,
    ST_RD_BACK  = 6'b001000,
    ST_RD_DONE  = 6'b010000,
    ST_RESULT   = 6'b100000
  } olc_state_e;

  olc_state_e            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  ok_q, ok_d;
  logic [ENTRY_BITS-1:0] front_q, front_d;
  logic [ENTRY_BITS-1:0] back_q, back_d;

  logic [31:0]           pos_ext;
  logic [31:0]           cnt_ext;
  logic [IDX_W-1:0]      pos_idx;
  logic                  list_empty;

  assign pos_ext    = 32'(entry_position_i);
  assign cnt_ext    = 32'(cnt_q);
  assign pos_idx    = IDX_W'(pos_ext);
  assign list_empty = (cnt_q == '0);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ok_d        = ok_q;
    front_d     = front_q;
    back_d      = back_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = pos_idx + IDX_W'(1);
        if (in_valid_i) begin
          ok_d    = 1'b1;
          state_d = ST_RD_FRONT;
          case (action_i)
            ACT_PUSH: begin
              if (cnt_q < CNT_W'(CAPACITY)) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = IDX_W'(cnt_q);
                mem_wdata_o = ENTRY_BITS'(64'(entry_value_i));
                cnt_d       = cnt_q + CNT_W'(1);
              end else begin
                ok_d = 1'b0;
              end
            end
            ACT_REMOVE: begin
              if (pos_ext < cnt_ext) begin
                cnt_d = cnt_q - CNT_W'(1);
                idx_d = pos_idx;
                if (pos_ext + 32'd1 < cnt_ext) begin
                  state_d = ST_SHIFT;
                end
              end else begin
                ok_d = 1'b0;
              end
            end
            ACT_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        // entry idx+1 arrives from ram, lands at idx; next read runs one ahead
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        mem_raddr_o = idx_q + IDX_W'(2);
        idx_d       = idx_q + IDX_W'(1);
        if ((CNT_W'(idx_q) + CNT_W'(1)) >= cnt_q) begin
          state_d = ST_RD_FRONT;
        end
      end
      ST_RD_FRONT: begin
        mem_raddr_o = '0;
        state_d     = ST_RD_BACK;
      end
      ST_RD_BACK: begin
        front_d     = mem_rdata_i;
        mem_raddr_o = IDX_W'(cnt_q - CNT_W'(1));
        state_d     = ST_RD_DONE;
      end
      ST_RD_DONE: begin
        back_d  = mem_rdata_i;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.accepted    = ok_q;
    res_o.list_empty  = list_empty;
    res_o.entry_count = OUT_CNT_W'(cnt_q);
    res_o.front_value = list_empty ? '0 : VALUE_W'(64'(front_q));
    res_o.back_value  = list_empty ? '0 : VALUE_W'(64'(back_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    ok_q    <= ok_d;
    front_q <= front_d;
    back_q  <= back_d;
  end

endmodule

`default_nettype wire

FILE: sv/ordered_list_with_compaction_unit.sv
// Bounded ordered list with remove-at-position compaction, top level.
//
// Input stream s_axis: one transaction carries one action (tuser) plus a value
// and a position (tdata). Push appends at the tail, remove deletes a position
// and moves later entries down by one, clear empties the list, peek reads only.
// Output stream m_axis: one transaction per input transaction with the status,
// front and back entries, empty flag and entry count after the action.
//
// One action is worked on at a time. An input transaction is taken only when
// the sequencer is idle; it then takes a shift step for every entry that a
// remove moves down (count - 1 - position, at most 15), reads the front and
// back entries and offers the result, which waits while the output register
// is full. The sequencer is idle again once it hands the result on. The shift
// moves one entry per cycle through the single-port-write entry ram, which sets the rate.
//
// Reset clears the entry count and all handshake state; the entry ram is not
// cleared. A stalled receiver holds the result in the output register; the
// next action may be taken meanwhile, and its result waits in the sequencer.
`default_nettype none

module ordered_list_with_compaction_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // entry_value [31:0], entry_position [35:32], zero pad [39:36]
  input  wire logic [olc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action [1:0]
  input  wire logic [olc_pkg::ACTION_W-1:0]      s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // accepted [0], front_value [32:1], back_value [64:33], list_empty [65],
  // entry_count [70:66], zero pad [71]
  output logic [olc_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  import olc_pkg::*;

  logic                  res_valid;
  logic                  res_ready;
  olc_result_t           res;
  olc_result_t           out_q;
  logic                  out_valid_q;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ENTRY_BITS-1:0] mem_rdata;

  olc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .action_i         (olc_action_e'(s_axis_tuser)),
    .entry_value_i    (s_axis_tdata[VALUE_W-1:0]),
    .entry_position_i (s_axis_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  olc_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.entry_count, out_q.list_empty, out_q.back_value,
                          out_q.front_value, out_q.accepted};

endmodule

`default_nettype wire

FILE: sv/olc_checker.sv
// port-level assertions for the ordered list unit, bound to the top level
`default_nettype none

module olc_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic [olc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import olc_pkg::*;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one action at a time: no transaction right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[70:66] <= OUT_CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[65] == (m_axis_tdata[70:66] == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[64:1] == '0)
    else $error("empty list shows nonzero front or back");

endmodule

bind ordered_list_with_compaction_unit olc_checker u_olc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/ordered_list_with_compaction_unit_tb.sv
// self-checking testbench for the ordered list unit with random stream traffic
`timescale 1ns / 1ps

module ordered_list_with_compaction_unit_tb;
  import olc_pkg::*;

  typedef struct {
    olc_action_e      action;
    logic [31:0]      value;
    logic [3:0]       position;
    bit               drain_first;
  } list_cmd_t;

  localparam int unsigned RANDOM_CMDS = 400;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // entry_value [31:0], entry_position [35:32], zero pad [39:36]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // action [1:0]
  logic [ACTION_W-1:0]   s_axis_tuser  = ACT_PEEK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // accepted [0], front_value [32:1], back_value [64:33], list_empty [65],
  // entry_count [70:66], zero pad [71]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  list_cmd_t   cmd_q[$];
  olc_result_t pending_results[$];

  logic [31:0] list_mem [CAPACITY];
  int unsigned list_len      = 0;
  int unsigned gen_len       = 0;
  int unsigned total_cmds    = 0;
  int unsigned in_cnt        = 0;
  int unsigned offered_cnt   = 0;
  int unsigned out_cnt       = 0;
  int unsigned err_cnt       = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_cycle      = 0;
  bit          long_hold_done = 0;
  int unsigned n_full_refused = 0;
  int unsigned n_pos_refused  = 0;
  int unsigned n_shifted      = 0;
  int unsigned peak_len       = 0;

  ordered_list_with_compaction_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in result %0d: %s is %0h, expected %0h", out_cnt, field, got, want);
    err_cnt++;
  endtask

  // list state after one action and the status it reports
  task automatic apply_list_action(input olc_action_e act, input logic [31:0] value,
                                   input logic [3:0] pos);
    olc_result_t res;
    int unsigned k;
    res.accepted = 1'b1;
    case (act)
      ACT_PUSH: begin
        if (list_len >= CAPACITY) begin
          res.accepted = 1'b0;
          n_full_refused++;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= list_len) begin
          res.accepted = 1'b0;
          n_pos_refused++;
        end else begin
          for (k = pos; k + 1 < list_len; k++) begin
            list_mem[k] = list_mem[k + 1];
            n_shifted++;
          end
          list_len--;
        end
      end
      ACT_CLEAR: list_len = 0;
      default: ;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    res.list_empty  = (list_len == 0);
    res.front_value = (list_len == 0) ? '0 : list_mem[0];
    res.back_value  = (list_len == 0) ? '0 : list_mem[list_len - 1];
    res.entry_count = list_len[OUT_CNT_W-1:0];
    pending_results.push_back(res);
  endtask

  task automatic add_cmd(input olc_action_e act, input logic [31:0] value,
                         input logic [3:0] pos, input bit drain);
    list_cmd_t c;
    c.action      = act;
    c.value       = value;
    c.position    = pos;
    c.drain_first = drain;
    cmd_q.push_back(c);
    total_cmds++;
    case (act)
      ACT_PUSH:   if (gen_len < CAPACITY) gen_len++;
      ACT_REMOVE: if (pos < gen_len) gen_len--;
      ACT_CLEAR:  gen_len = 0;
      default: ;
    endcase
  endtask

  // sender: drives at the falling edge
  always @(negedge clk_i) begin
    list_cmd_t c;
    if (rst_ni && !(s_axis_tvalid && in_cnt != offered_cnt)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (cmd_q.size() == 0 ||
                   (cmd_q[0].drain_first && pending_results.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        c = cmd_q.pop_front();
        s_axis_tdata  <= {4'b0, c.position, c.value};
        s_axis_tuser  <= c.action;
        s_axis_tvalid <= 1'b1;
        offered_cnt++;
        if (offered_cnt % 100 < 30) begin
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:59]:  gap_left = 0;
            [60:89]: gap_left = $urandom_range(1, 3);
            [90:97]: gap_left = $urandom_range(4, 15);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end
    end
  end

  // receiver: ready pattern with one long hold-off while the sender keeps going
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && in_cnt >= 100) begin
        long_hold_done = 1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else if (rx_cycle % 400 < 100) begin
        m_axis_tready <= 1'b1;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]: m_axis_tready <= 1'b1;
          [70:94]: begin
            hold_left = $urandom_range(1, 3);
            m_axis_tready <= 1'b0;
          end
          default: begin
            hold_left = $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
          end
        endcase
      end
    end
  end

  // input side: predict on every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      apply_list_action(olc_action_e'(s_axis_tuser), s_axis_tdata[31:0],
                        s_axis_tdata[35:32]);
      in_cnt++;
    end
  end

  // output side: compare with the oldest expected result
  always @(posedge clk_i) begin
    olc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result transaction %0d: %0h", out_cnt, m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.accepted)
          report_mismatch("accepted", m_axis_tdata[0], want.accepted);
        if (m_axis_tdata[32:1] !== want.front_value)
          report_mismatch("front_value", m_axis_tdata[32:1], want.front_value);
        if (m_axis_tdata[64:33] !== want.back_value)
          report_mismatch("back_value", m_axis_tdata[64:33], want.back_value);
        if (m_axis_tdata[65] !== want.list_empty)
          report_mismatch("list_empty", m_axis_tdata[65], want.list_empty);
        if (m_axis_tdata[70:66] !== want.entry_count)
          report_mismatch("entry_count", m_axis_tdata[70:66], want.entry_count);
      end
      out_cnt++;
    end
  end

  initial begin
    int unsigned i;
    int unsigned r;
    bit          fill_mode;
    logic [31:0] v;
    logic [3:0]  p;

    // directed: empty list, extremes, full list, removes at both ends and past the end
    add_cmd(ACT_PEEK, 32'h0, 4'd0, 0);
    add_cmd(ACT_REMOVE, $urandom, 4'd0, 0);
    add_cmd(ACT_PUSH, 32'hFFFF_FFFF, 4'd15, 0);
    add_cmd(ACT_PUSH, 32'h0, 4'd0, 0);
    for (i = 0; i < 14; i++) add_cmd(ACT_PUSH, $urandom, 4'($urandom), 0);
    add_cmd(ACT_PUSH, 32'hA5A5_5A5A, 4'd0, 0);
    add_cmd(ACT_REMOVE, $urandom, 4'd15, 0);
    add_cmd(ACT_REMOVE, $urandom, 4'd0, 0);
    add_cmd(ACT_REMOVE, $urandom, 4'd15, 0);
    add_cmd(ACT_CLEAR, $urandom, 4'($urandom), 0);
    add_cmd(ACT_PEEK, $urandom, 4'($urandom), 0);

    // random: alternating fill and drain phases, mostly valid positions
    for (i = 0; i < RANDOM_CMDS; i++) begin
      fill_mode = ((i / 40) % 2) == 0;
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0)
                                      : $urandom;
      if (gen_len > 0 && $urandom_range(0, 9) < 8)
        p = 4'($urandom_range(0, gen_len - 1));
      else
        p = 4'($urandom_range(0, 15));
      if (r < (fill_mode ? 65 : 25))
        add_cmd(ACT_PUSH, v, p, i == 0 || i == 200);
      else if (r < (fill_mode ? 85 : 80))
        add_cmd(ACT_REMOVE, v, p, i == 0 || i == 200);
      else if (r < (fill_mode ? 88 : 83))
        add_cmd(ACT_CLEAR, v, p, i == 0 || i == 200);
      else
        add_cmd(ACT_PEEK, v, p, i == 0 || i == 200);
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (in_cnt != total_cmds) @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("%0d actions and %0d results, %0d pushes refused on a full list,",
             total_cmds, out_cnt, n_full_refused);
    $display("%0d removes out of range, %0d entries shifted, peak fill %0d of %0d",
             n_pos_refused, n_shifted, peak_len, CAPACITY);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout after %0d of %0d actions, %0d results", in_cnt, total_cmds, out_cnt);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
